// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge while reset is released.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed: %m");
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed: %m");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== rtl/fsa_pkg.sv =====
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared widths, codes, defaults and control types of the slot allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fsa_pkg;

  // Default configuration.
  localparam int FSA_FRAMES          = 16;
  localparam int FSA_SLOTS_PER_FRAME = 8;
  localparam int FSA_VALUE_BITS      = 32;

  // Fixed field widths of the channels.
  localparam int REQ_W     = 2;
  localparam int STORE_W   = 32;
  localparam int TARGET_W  = 8;
  localparam int STATUS_W  = 2;
  localparam int GRANTED_W = 7;
  localparam int RVALUE_W  = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture a request and issue the memory reads
    logic commit;  // apply the update and load the result register
  } fsa_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/fsa_if.sv =====
// ----------------------------------------------------------------------------
// fsa_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface fsa_in_if
  import fsa_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic                has_value;
  logic [STORE_W-1:0]  store_value;
  logic [TARGET_W-1:0] target_index;

  modport source (output valid, output req_type, output has_value,
                  output store_value, output target_index, input ready);
  modport sink   (input valid, input req_type, input has_value,
                  input store_value, input target_index, output ready);
endinterface

interface fsa_out_if
  import fsa_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [GRANTED_W-1:0] granted_index;
  logic [RVALUE_W-1:0]  read_value;

  modport source (output valid, output status, output granted_index,
                  output read_value, input ready);
  modport sink   (input valid, input status, input granted_index,
                  input read_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/fsa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fsa_ctrl
// Request sequencer: accepts a word, waits for result space, commits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fsa_ctrl
  import fsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  output fsa_cmd_t      cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic commit;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  // The result register may be refilled in the cycle its word is taken.
  assign commit   = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  assign cmd_o.load   = accept;
  assign cmd_o.commit = commit;
  assign out_valid    = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_RST(a_accept_to_exec, clk, rst_n, (in_valid && in_ready) |=> (state_r == S_EXEC))
  `ASSERT_RST(a_commit_result, clk, rst_n, commit |=> ((state_r == S_IDLE) && out_valid_r))
  `ASSERT_RST(a_valid_from_commit, clk, rst_n, $rose(out_valid_r) |-> $past(commit))
  `ASSERT_RST(a_hold_when_blocked, clk, rst_n, ((state_r == S_EXEC) && out_valid_r && !out_ready) |=> (state_r == S_EXEC))

endmodule

`default_nettype wire

// ===== rtl/fsa_dpath.sv =====
// ----------------------------------------------------------------------------
// fsa_dpath
// Occupancy rows, full flags, value store and result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fsa_dpath
  import fsa_pkg::*;
#(
  parameter int FRAMES          = FSA_FRAMES,
  parameter int SLOTS_PER_FRAME = FSA_SLOTS_PER_FRAME,
  parameter int VALUE_BITS      = FSA_VALUE_BITS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fsa_cmd_t             cmd_i,
  input  wire logic [REQ_W-1:0]     req_type,
  input  wire logic                 has_value,
  input  wire logic [STORE_W-1:0]   store_value,
  input  wire logic [TARGET_W-1:0]  target_index,
  output logic [STATUS_W-1:0]       res_status,
  output logic [GRANTED_W-1:0]      res_granted,
  output logic [RVALUE_W-1:0]       res_value
);

  localparam int SpfEff     = ((SLOTS_PER_FRAME + 7) / 8) * 8;
  localparam int Capacity   = FRAMES * SpfEff;
  localparam int FrW        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SlW        = $clog2(SpfEff);
  localparam int GW         = $clog2(Capacity);
  // Reciprocal for the frame number of a target index: exact for 8-bit indexes.
  localparam int RecipShift = 16;
  localparam int RecipW     = RecipShift + 1;
  localparam int Recip      = ((1 << RecipShift) + SpfEff - 1) / SpfEff;
  localparam int ProdW      = TARGET_W + RecipW;
  localparam logic [VALUE_BITS-1:0] ByteFill = VALUE_BITS'(64'h0101_0101_0101_0101);

  // Storage.
  logic [SpfEff-1:0]     occ_mem_r [FRAMES];
  logic [VALUE_BITS-1:0] val_mem_r [Capacity];
  logic [FRAMES-1:0]     row_valid_r;
  logic [FRAMES-1:0]     full_r;

  // Request captured at accept.
  logic [REQ_W-1:0]      req_r;
  logic                  has_value_r;
  logic [STORE_W-1:0]    store_value_r;
  logic [TARGET_W-1:0]   target_r;
  logic [FrW-1:0]        frame_r;
  logic                  in_range_r;
  logic                  space_r;
  logic [SpfEff-1:0]     occ_rd_r;
  logic                  row_valid_rd_r;
  logic [VALUE_BITS-1:0] val_rd_r;

  // Result register.
  logic [STATUS_W-1:0]   res_status_r;
  logic [GRANTED_W-1:0]  res_granted_r;
  logic [RVALUE_W-1:0]   res_value_r;

  // Accept-cycle logic.
  logic [FrW-1:0]        pick;
  logic                  space;
  logic [ProdW-1:0]      prod;
  logic [TARGET_W-1:0]   tgt_frame;
  logic [FrW-1:0]        rd_frame;
  logic                  in_range;

  // Execute-cycle logic.
  logic [SpfEff-1:0]     row;
  logic [SlW-1:0]        free_slot;
  logic                  found;
  logic [SlW-1:0]        tgt_slot;
  logic [GW-1:0]         g_alloc;
  logic                  hit;
  logic                  alloc_ok;
  logic [VALUE_BITS-1:0] wval;
  logic [SpfEff-1:0]     new_row;
  logic                  row_we;
  logic [STATUS_W-1:0]   status_c;
  logic [GRANTED_W-1:0]  granted_c;
  logic [RVALUE_W-1:0]   value_c;

  // Lowest frame that still has a free slot.
  always_comb begin
    pick  = '0;
    space = 1'b0;
    for (int f = FRAMES - 1; f >= 0; f--) begin
      if (!full_r[f]) begin
        pick  = FrW'(f);
        space = 1'b1;
      end
    end
  end

  assign prod      = ProdW'(target_index) * ProdW'(Recip);
  assign tgt_frame = prod[RecipShift +: TARGET_W];
  assign in_range  = (int'(target_index) < Capacity);
  assign rd_frame  = (req_type == REQ_ALLOC) ? pick : tgt_frame[FrW-1:0];

  always_ff @(posedge clk) begin
    if (cmd_i.load) begin
      req_r          <= req_type;
      has_value_r    <= has_value;
      store_value_r  <= store_value;
      target_r       <= target_index;
      frame_r        <= rd_frame;
      in_range_r     <= in_range;
      space_r        <= space;
      occ_rd_r       <= occ_mem_r[rd_frame];
      row_valid_rd_r <= row_valid_r[rd_frame];
      val_rd_r       <= val_mem_r[GW'(target_index)];
    end
  end

  // A row that was never written reads as all free.
  assign row = row_valid_rd_r ? occ_rd_r : '0;

  always_comb begin
    free_slot = '0;
    found     = 1'b0;
    for (int i = SpfEff - 1; i >= 0; i--) begin
      if (!row[i]) begin
        free_slot = SlW'(i);
        found     = 1'b1;
      end
    end
  end

  assign tgt_slot = SlW'(int'(target_r) - int'(frame_r) * SpfEff);
  assign g_alloc  = GW'(int'(frame_r) * SpfEff + int'(free_slot));
  assign hit      = in_range_r && row[tgt_slot];
  assign alloc_ok = space_r && found;
  assign wval     = has_value_r ? VALUE_BITS'(store_value_r) : ByteFill;

  always_comb begin
    new_row   = row;
    row_we    = 1'b0;
    status_c  = ST_EMPTY;
    granted_c = '0;
    value_c   = '0;
    case (req_r)
      REQ_ALLOC: begin
        if (alloc_ok) begin
          new_row[free_slot] = 1'b1;
          row_we    = 1'b1;
          status_c  = ST_OK;
          granted_c = GRANTED_W'(g_alloc);
          value_c   = RVALUE_W'(wval);
        end else begin
          status_c = ST_FULL;
        end
      end
      REQ_READ: begin
        if (hit) begin
          status_c = ST_OK;
          value_c  = RVALUE_W'(val_rd_r);
        end
      end
      REQ_FREE: begin
        if (hit) begin
          new_row[tgt_slot] = 1'b0;
          row_we   = 1'b1;
          status_c = ST_OK;
        end
      end
      default: status_c = ST_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit && row_we) begin
      occ_mem_r[frame_r] <= new_row;
    end
    if (cmd_i.commit && (req_r == REQ_ALLOC) && alloc_ok) begin
      val_mem_r[g_alloc] <= wval;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      full_r      <= '0;
    end else if (cmd_i.commit && row_we) begin
      row_valid_r[frame_r] <= 1'b1;
      full_r[frame_r]      <= &new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.commit) begin
      res_status_r  <= status_c;
      res_granted_r <= granted_c;
      res_value_r   <= value_c;
    end
  end

  assign res_status  = res_status_r;
  assign res_granted = res_granted_r;
  assign res_value   = res_value_r;

  `ASSERT_RST(a_alloc_marks_row, clk, rst_n, (cmd_i.commit && (req_r == REQ_ALLOC) && alloc_ok) |=> row_valid_r[frame_r])
  `ASSERT_RST(a_free_clears_full, clk, rst_n, (cmd_i.commit && (req_r == REQ_FREE) && hit) |=> !full_r[frame_r])
  `ASSERT_RST(a_full_only_no_space, clk, rst_n, (cmd_i.commit && (req_r == REQ_ALLOC) && !space_r) |=> (res_status_r == ST_FULL))

endmodule

`default_nettype wire

// ===== rtl/framed_slot_allocator_top.sv =====
// ----------------------------------------------------------------------------
// framed_slot_allocator_top
// Framed slot pool: allocate lowest free slot, read and free by index.
// ----------------------------------------------------------------------------
// Sequence: an accepted request word is captured with its row and value reads; the
//   update and result register are loaded in the execute state, later only while
//   the previous result word is still waiting to be taken. A new request word is not
//   accepted before the last commits, as each must see the row the last one wrote.
// Reset clears the per-frame row valid bits and full flags at once; no clearing
//   pass is needed. Stored values are undefined until a slot is allocated.
`default_nettype none

module framed_slot_allocator_top
  import fsa_pkg::*;
#(
  parameter int FRAMES          = FSA_FRAMES,
  parameter int SLOTS_PER_FRAME = FSA_SLOTS_PER_FRAME,
  parameter int VALUE_BITS      = FSA_VALUE_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  fsa_in_if.sink     in_ch,
  fsa_out_if.source  out_ch
);

  fsa_cmd_t cmd;
  logic     in_ready;
  logic     out_valid;

  fsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd_o     (cmd)
  );

  fsa_dpath #(
    .FRAMES          (FRAMES),
    .SLOTS_PER_FRAME (SLOTS_PER_FRAME),
    .VALUE_BITS      (VALUE_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .req_type     (in_ch.req_type),
    .has_value    (in_ch.has_value),
    .store_value  (in_ch.store_value),
    .target_index (in_ch.target_index),
    .res_status   (out_ch.status),
    .res_granted  (out_ch.granted_index),
    .res_value    (out_ch.read_value)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the framed slot allocator. A behavioral copy of the
// slot pool predicts every result word from the accepted request words, and
// the results are compared field by field in order. A short directed run
// covers the corner cases. It is followed by random traffic in fill, mixed and
// drain blocks that takes the pool to full and back, under changing back
// pressure on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top
  import fsa_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SPF_EFF  = ((FSA_SLOTS_PER_FRAME + 7) / 8) * 8;
  localparam int CAPACITY = FSA_FRAMES * SPF_EFF;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [STORE_W-1:0] BYTE_FILL = 32'h0101_0101;
  localparam int WORDS_PER_PHASE = 650;
  localparam int BLOCK_LEN = 130;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic                has_value;
    logic [STORE_W-1:0]  value;
    logic [TARGET_W-1:0] target;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [GRANTED_W-1:0] granted_index;
    logic [RVALUE_W-1:0]  read_value;
  } reply_t;

  // Mirror of the slot pool plus the replies still owed by the block.
  class slot_pool_tracker;
    bit                 occupied[CAPACITY];
    logic [STORE_W-1:0] slot_value[CAPACITY];
    int unsigned        frame_fill[FSA_FRAMES];
    reply_t             owed_replies[$];
    int unsigned        mismatches;

    function new();
      foreach (occupied[i]) occupied[i] = 1'b0;
      foreach (frame_fill[i]) frame_fill[i] = 0;
      mismatches = 0;
    endfunction

    function int unsigned occupancy();
      int unsigned total;
      total = 0;
      foreach (frame_fill[i]) total += frame_fill[i];
      return total;
    endfunction

    function int unsigned pending();
      return owed_replies.size();
    endfunction

    function void note_request(request_t w);
      reply_t      e;
      int unsigned f;
      int unsigned s;
      int unsigned g;
      bit          searched;
      e = '0;
      e.status = ST_EMPTY;
      if (w.req == REQ_ALLOC) begin
        e.status = ST_FULL;
        searched = 1'b0;
        // Only the first frame that is not full is searched.
        for (f = 0; f < FSA_FRAMES && !searched; f++) begin
          if (frame_fill[f] != SPF_EFF) begin
            searched = 1'b1;
            for (s = 0; s < SPF_EFF; s++) begin
              g = f * SPF_EFF + s;
              if (!occupied[g] && e.status != ST_OK) begin
                e.status        = ST_OK;
                e.granted_index = GRANTED_W'(g);
                e.read_value    = w.has_value ? w.value : BYTE_FILL;
                occupied[g]     = 1'b1;
                slot_value[g]   = e.read_value;
                frame_fill[f]++;
              end
            end
          end
        end
      end else if (w.req == REQ_READ || w.req == REQ_FREE) begin
        if (w.target < CAPACITY && occupied[w.target]) begin
          e.status = ST_OK;
          if (w.req == REQ_READ) begin
            e.read_value = slot_value[w.target];
          end else begin
            occupied[w.target] = 1'b0;
            f = w.target / SPF_EFF;
            if (frame_fill[f] > 0) frame_fill[f]--;
          end
        end
      end
      owed_replies = {owed_replies, e};
    endfunction

    function void check_result(reply_t act);
      reply_t e;
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected result word status=%0d index=%0d value=%h",
                 $time, act.status, act.granted_index, act.read_value);
        mismatches++;
        return;
      end
      e = owed_replies.pop_front();
      if (act.status != e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, act.status);
        mismatches++;
      end
      if (act.granted_index != e.granted_index) begin
        $display("%0t: granted_index expected %0d actual %0d",
                 $time, e.granted_index, act.granted_index);
        mismatches++;
      end
      if (act.read_value != e.read_value) begin
        $display("%0t: read_value expected %h actual %h",
                 $time, e.read_value, act.read_value);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_idle_pct;

  slot_pool_tracker pool;

  fsa_in_if  in_ch ();
  fsa_out_if out_ch ();

  framed_slot_allocator_top uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic request_t make_word(logic [REQ_W-1:0] req, logic hv,
                                         logic [STORE_W-1:0] val,
                                         logic [TARGET_W-1:0] tgt);
    request_t w;
    w.req       = req;
    w.has_value = hv;
    w.value     = val;
    w.target    = tgt;
    return w;
  endfunction

  // Fill blocks push the pool to full, drain blocks empty it again.
  function automatic request_t next_random_word(int block);
    request_t    w;
    int unsigned roll;
    int unsigned k;
    int          alloc_cut;
    int          read_cut;
    case (block % 4)
      0, 1: begin alloc_cut = 85; read_cut = 93; end
      2: begin alloc_cut = 40; read_cut = 70; end
      default: begin alloc_cut = 10; read_cut = 35; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < alloc_cut) w.req = REQ_ALLOC;
    else if (roll < read_cut) w.req = REQ_READ;
    else if (roll < 97) w.req = REQ_FREE;
    else w.req = REQ_UNUSED;
    w.has_value = 1'($urandom_range(0, 1));
    w.value     = $urandom;
    roll = $urandom_range(0, 99);
    if (roll < 70 && pool.occupancy() > 0) begin
      k = $urandom_range(0, CAPACITY - 1);
      while (!pool.occupied[k]) k = (k + 1) % CAPACITY;
      w.target = TARGET_W'(k);
    end else if (roll < 88) begin
      w.target = TARGET_W'($urandom_range(0, CAPACITY - 1));
    end else begin
      w.target = TARGET_W'($urandom_range(0, 255));
    end
    return w;
  endfunction

  // Called just after a falling edge; returns just after the falling edge
  // that follows the accepting rising edge.
  task automatic send_word(request_t w);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.req_type     <= w.req;
    in_ch.has_value    <= w.has_value;
    in_ch.store_value  <= w.value;
    in_ch.target_index <= w.target;
    do @(posedge clk); while (!in_ch.ready);
    pool.note_request(w);
    @(negedge clk);
  endtask

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pool.check_result({out_ch.status, out_ch.granted_index, out_ch.read_value});
    end
  end

  initial begin
    #10ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int phase;
    int n;
    pool = new();
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = REQ_ALLOC;
    in_ch.has_value    = 1'b0;
    in_ch.store_value  = '0;
    in_ch.target_index = '0;
    send_idle_pct      = 9;
    recv_idle_pct      = 85;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed corners: empty pool, byte fill, value extremes, out of range
    // indexes, double free, slot reuse and the unused request code.
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd0));
    send_word(make_word(REQ_FREE,   1'b0, '0,           8'd0));
    send_word(make_word(REQ_ALLOC,  1'b0, 32'h1234_5678, 8'd0));
    send_word(make_word(REQ_ALLOC,  1'b1, 32'hFFFF_FFFF, 8'd0));
    send_word(make_word(REQ_ALLOC,  1'b1, 32'h0000_0000, 8'hFF));
    send_word(make_word(REQ_ALLOC,  1'b0, 32'hFFFF_FFFF, 8'hFF));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd0));
    send_word(make_word(REQ_READ,   1'b1, 32'hFFFF_FFFF, 8'd1));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd2));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd3));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd127));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd128));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd255));
    send_word(make_word(REQ_FREE,   1'b0, '0,           8'd255));
    send_word(make_word(REQ_FREE,   1'b0, '0,           8'd128));
    send_word(make_word(REQ_FREE,   1'b0, '0,           8'd1));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd1));
    send_word(make_word(REQ_FREE,   1'b0, '0,           8'd1));
    send_word(make_word(REQ_ALLOC,  1'b1, 32'hA5A5_A5A5, 8'd0));
    send_word(make_word(REQ_READ,   1'b0, '0,           8'd1));
    send_word(make_word(REQ_UNUSED, 1'b1, 32'hFFFF_FFFF, 8'hFF));
    send_word(make_word(REQ_UNUSED, 1'b0, '0,           8'd0));
    send_word(make_word(REQ_FREE,   1'b0, '0,           8'd0));

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 9;  recv_idle_pct = 85; end
        1: begin send_idle_pct = 85; recv_idle_pct = 9;  end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        send_word(next_random_word((phase * WORDS_PER_PHASE + n) / BLOCK_LEN));
      end
    end
    in_ch.valid <= 1'b0;

    while (pool.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pool.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
